// File: rtl/gkb_pkg.sv
`timescale 1ns / 1ps

package gkb_pkg;

  localparam int GRID_MAX   = 16;
  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 8;

  localparam int GRID_BITS  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int SLOT_BITS  = 2 * GRID_BITS;
  localparam int SLOTS      = 2 ** SLOT_BITS;
  localparam int DIV_BITS   = COORD_BITS + GRID_BITS;
  localparam int STEP_BITS  = (GRID_BITS > 1) ? $clog2(GRID_BITS) : 1;

  localparam int SIZE_BITS  = 12;
  localparam int GCFG_BITS  = 5;
  localparam int MAXC_BITS  = 8;
  localparam int CFG_BITS   = 12;
  localparam int CIDX_BITS  = 2;

  localparam logic [CIDX_BITS-1:0] CFG_CELL_HEIGHT  = 2'd0;
  localparam logic [CIDX_BITS-1:0] CFG_CELL_WIDTH   = 2'd1;
  localparam logic [CIDX_BITS-1:0] CFG_GRID_CELLS   = 2'd2;
  localparam logic [CIDX_BITS-1:0] CFG_MAX_PER_CELL = 2'd3;

  localparam logic [SIZE_BITS-1:0] RST_CELL_HEIGHT  = 12'd30;
  localparam logic [SIZE_BITS-1:0] RST_CELL_WIDTH   = 12'd40;
  localparam logic [GCFG_BITS-1:0] RST_GRID_CELLS   = 5'd16;
  localparam logic [MAXC_BITS-1:0] RST_MAX_PER_CELL = 8'd10;

  typedef struct packed {
    logic                 new_frame;
    logic [GRID_BITS-1:0] row;
    logic [GRID_BITS-1:0] col;
  } gkb_cell_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIVIDE,
    F_PUSH
  } gkb_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_UPDATE
  } gkb_back_state_t;

  // index of the last usable cell per side; zero acts as one, oversize as GRID_MAX
  function automatic logic [GRID_BITS-1:0] grid_last(input logic [GCFG_BITS-1:0] g);
    logic [GRID_BITS-1:0] res;
    if (g == '0) begin
      res = '0;
    end else if (int'(g) > GRID_MAX) begin
      res = GRID_BITS'(GRID_MAX - 1);
    end else begin
      res = GRID_BITS'(g - 1'b1);
    end
    return res;
  endfunction

endpackage

// File: rtl/gkb_if.sv
`timescale 1ns / 1ps

interface gkb_in_if;
  logic                            valid;
  logic                            ready;
  logic [gkb_pkg::COORD_BITS-1:0]  point_x;
  logic [gkb_pkg::COORD_BITS-1:0]  point_y;
  logic                            new_frame;

  modport source (output valid, output point_x, output point_y, output new_frame,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input new_frame,
                output ready);
endinterface

interface gkb_out_if;
  logic                            valid;
  logic                            ready;
  logic                            keep;
  logic [gkb_pkg::GRID_BITS-1:0]   cell_row;
  logic [gkb_pkg::GRID_BITS-1:0]   cell_col;
  logic [gkb_pkg::COUNT_BITS-1:0]  cell_count;

  modport source (output valid, output keep, output cell_row, output cell_col,
                  output cell_count, input ready);
  modport sink (input valid, input keep, input cell_row, input cell_col,
                input cell_count, output ready);
endinterface

// File: rtl/gkb_front.sv
`timescale 1ns / 1ps

module gkb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  gkb_in_if.sink                          in_ch,
  input  logic [gkb_pkg::SIZE_BITS-1:0]   cell_height,
  input  logic [gkb_pkg::SIZE_BITS-1:0]   cell_width,
  input  logic [gkb_pkg::GCFG_BITS-1:0]   grid_cells,
  output logic                            push_valid,
  output gkb_pkg::gkb_cell_t              push_data,
  input  logic                            q_full
);

  gkb_pkg::gkb_front_state_t state_r, state_nxt;

  logic [gkb_pkg::COORD_BITS-1:0] x_rem_r, y_rem_r;
  logic [gkb_pkg::GRID_BITS-1:0]  x_quo_r, y_quo_r;
  logic                           x_ovf_r, y_ovf_r;
  logic                           frame_r;
  logic [gkb_pkg::STEP_BITS-1:0]  step_r;

  logic                           accept;
  logic [gkb_pkg::DIV_BITS-1:0]   x_trial, y_trial;
  logic                           x_ge, y_ge;
  logic [gkb_pkg::GRID_BITS-1:0]  last;

  assign accept = in_ch.valid && in_ch.ready;

  // shifted divisor for the current quotient bit
  assign x_trial = {{gkb_pkg::GRID_BITS{1'b0}}, cell_width} << step_r;
  assign y_trial = {{gkb_pkg::GRID_BITS{1'b0}}, cell_height} << step_r;
  assign x_ge    = {{gkb_pkg::GRID_BITS{1'b0}}, x_rem_r} >= x_trial;
  assign y_ge    = {{gkb_pkg::GRID_BITS{1'b0}}, y_rem_r} >= y_trial;
  assign last    = gkb_pkg::grid_last(grid_cells);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gkb_pkg::F_IDLE: begin
        if (accept) state_nxt = gkb_pkg::F_DIVIDE;
      end
      gkb_pkg::F_DIVIDE: begin
        if (step_r == '0) state_nxt = gkb_pkg::F_PUSH;
      end
      gkb_pkg::F_PUSH: begin
        if (!q_full) state_nxt = gkb_pkg::F_IDLE;
      end
      default: state_nxt = gkb_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == gkb_pkg::F_IDLE);
    push_valid  = (state_r == gkb_pkg::F_PUSH);
  end

  always_comb begin
    push_data.new_frame = frame_r;
    push_data.row = (y_ovf_r || (y_quo_r > last)) ? last : y_quo_r;
    push_data.col = (x_ovf_r || (x_quo_r > last)) ? last : x_quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gkb_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_rem_r <= in_ch.point_x;
      y_rem_r <= in_ch.point_y;
      frame_r <= in_ch.new_frame;
      x_quo_r <= '0;
      y_quo_r <= '0;
      step_r  <= gkb_pkg::STEP_BITS'(gkb_pkg::GRID_BITS - 1);
      // quotient past the grid range, a zero cell size lands here too
      x_ovf_r <= {{gkb_pkg::GRID_BITS{1'b0}}, in_ch.point_x} >=
                 {cell_width, {gkb_pkg::GRID_BITS{1'b0}}};
      y_ovf_r <= {{gkb_pkg::GRID_BITS{1'b0}}, in_ch.point_y} >=
                 {cell_height, {gkb_pkg::GRID_BITS{1'b0}}};
    end else if (state_r == gkb_pkg::F_DIVIDE) begin
      if (x_ge) begin
        x_rem_r <= gkb_pkg::COORD_BITS'({{gkb_pkg::GRID_BITS{1'b0}}, x_rem_r} - x_trial);
        x_quo_r[step_r] <= 1'b1;
      end
      if (y_ge) begin
        y_rem_r <= gkb_pkg::COORD_BITS'({{gkb_pkg::GRID_BITS{1'b0}}, y_rem_r} - y_trial);
        y_quo_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
  end

endmodule

// File: rtl/gkb_queue.sv
`timescale 1ns / 1ps

module gkb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gkb_pkg::gkb_cell_t  push_data,
  output logic                full,
  input  logic                pop,
  output gkb_pkg::gkb_cell_t  pop_data,
  output logic                empty
);

  gkb_pkg::gkb_cell_t entry_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         fill_r;

  logic do_push, do_pop;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/gkb_back.sv
`timescale 1ns / 1ps

module gkb_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gkb_pkg::gkb_cell_t              pop_data,
  input  logic                            q_empty,
  output logic                            pop,
  input  logic [gkb_pkg::MAXC_BITS-1:0]   max_per_cell,
  gkb_out_if.source                       out_ch
);

  gkb_pkg::gkb_back_state_t state_r, state_nxt;

  logic [gkb_pkg::COUNT_BITS-1:0] cnt_mem [gkb_pkg::SLOTS];
  logic [gkb_pkg::SLOTS-1:0]      valid_r;
  logic [gkb_pkg::COUNT_BITS-1:0] rd_data_r;
  logic [gkb_pkg::GRID_BITS-1:0]  row_r, col_r;

  logic                           out_valid_r;
  logic                           keep_r;
  logic [gkb_pkg::GRID_BITS-1:0]  out_row_r, out_col_r;
  logic [gkb_pkg::COUNT_BITS-1:0] out_cnt_r;

  logic [gkb_pkg::SLOT_BITS-1:0]  pop_slot, cur_slot;
  logic                           out_free;
  logic [gkb_pkg::COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic                           keep;
  logic                           upd;

  assign pop_slot = {pop_data.row, pop_data.col};
  assign cur_slot = {row_r, col_r};
  assign out_free = !out_valid_r || out_ch.ready;
  assign upd      = (state_r == gkb_pkg::B_UPDATE);

  // never-written or cleared cells read as zero
  assign cnt_cur = valid_r[cur_slot] ? rd_data_r : '0;
  assign keep    = ({{(gkb_pkg::COUNT_BITS > gkb_pkg::MAXC_BITS ? 0 :
                      gkb_pkg::MAXC_BITS - gkb_pkg::COUNT_BITS + 1){1'b0}}, cnt_cur} <
                    {{(gkb_pkg::MAXC_BITS > gkb_pkg::COUNT_BITS ? 0 :
                      gkb_pkg::COUNT_BITS - gkb_pkg::MAXC_BITS + 1){1'b0}}, max_per_cell})
                   && (cnt_cur != '1);
  assign cnt_new = keep ? cnt_cur + 1'b1 : cnt_cur;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gkb_pkg::B_IDLE: begin
        if (!q_empty && out_free) state_nxt = gkb_pkg::B_READ;
      end
      gkb_pkg::B_READ:   state_nxt = gkb_pkg::B_UPDATE;
      gkb_pkg::B_UPDATE: state_nxt = gkb_pkg::B_IDLE;
      default:           state_nxt = gkb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state_r == gkb_pkg::B_IDLE) && !q_empty && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gkb_pkg::B_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && pop_data.new_frame) begin
        valid_r <= '0;
      end else if (upd && keep) begin
        valid_r[cur_slot] <= 1'b1;
      end
      if (upd) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r     <= pop_data.row;
      col_r     <= pop_data.col;
      rd_data_r <= cnt_mem[pop_slot];
    end
    if (upd && keep) begin
      cnt_mem[cur_slot] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      keep_r    <= keep;
      out_row_r <= row_r;
      out_col_r <= col_r;
      out_cnt_r <= cnt_new;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = keep_r;
  assign out_ch.cell_row   = out_row_r;
  assign out_ch.cell_col   = out_col_r;
  assign out_ch.cell_count = out_cnt_r;

endmodule

// File: rtl/grid_keypoint_bucketing.sv
`timescale 1ns / 1ps

// Grid keypoint bucketing. Each keypoint (integer pixel x, y) is placed in a
// cell of a square grid by dividing its coordinates by the configured cell
// width and height, with indices clamped to the last cell per side, and is kept
// only while that cell's count is below max_per_cell. A point with new_frame
// set clears all cell counts before it is counted. One result comes back for
// every point, in order. The front end accepts a point, runs two shift-subtract
// dividers side by side (one quotient bit per cycle for x and y together, one
// step counter shared) and hands the cell into a two-entry queue, waiting there
// while the queue is full; it takes no new point until then. The back end pops
// a cell when the output register is free, reads the count memory and then
// updates it, and takes no new cell before that update. Counts are cleared at
// once by reset or new_frame through per-cell valid bits; there is no clearing
// pass. Configuration writes take effect on the next edge and should be made
// while no point is in flight.
module grid_keypoint_bucketing (
  input  logic                            clk,
  input  logic                            rst_n,
  gkb_in_if.sink                          in_ch,
  gkb_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gkb_pkg::CIDX_BITS-1:0]   cfg_index,
  input  logic [gkb_pkg::CFG_BITS-1:0]    cfg_data
);

  logic [gkb_pkg::SIZE_BITS-1:0] cell_height_r, cell_width_r;
  logic [gkb_pkg::GCFG_BITS-1:0] grid_cells_r;
  logic [gkb_pkg::MAXC_BITS-1:0] max_per_cell_r;

  logic               push_valid, q_full, q_empty, pop;
  gkb_pkg::gkb_cell_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_height_r  <= gkb_pkg::RST_CELL_HEIGHT;
      cell_width_r   <= gkb_pkg::RST_CELL_WIDTH;
      grid_cells_r   <= gkb_pkg::RST_GRID_CELLS;
      max_per_cell_r <= gkb_pkg::RST_MAX_PER_CELL;
    end else if (cfg_we) begin
      case (cfg_index)
        gkb_pkg::CFG_CELL_HEIGHT:  cell_height_r  <= cfg_data[gkb_pkg::SIZE_BITS-1:0];
        gkb_pkg::CFG_CELL_WIDTH:   cell_width_r   <= cfg_data[gkb_pkg::SIZE_BITS-1:0];
        gkb_pkg::CFG_GRID_CELLS:   grid_cells_r   <= cfg_data[gkb_pkg::GCFG_BITS-1:0];
        gkb_pkg::CFG_MAX_PER_CELL: max_per_cell_r <= cfg_data[gkb_pkg::MAXC_BITS-1:0];
        default: ;
      endcase
    end
  end

  gkb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cell_height (cell_height_r),
    .cell_width  (cell_width_r),
    .grid_cells  (grid_cells_r),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  gkb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  gkb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_data     (pop_data),
    .q_empty      (q_empty),
    .pop          (pop),
    .max_per_cell (max_per_cell_r),
    .out_ch       (out_ch)
  );

endmodule

// File: test/gkb_bucket_checker.sv
`timescale 1ns / 1ps

module gkb_bucket_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  gkb_in_if                             in_ch,
  gkb_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [gkb_pkg::CIDX_BITS-1:0] cfg_index,
  input  logic [gkb_pkg::CFG_BITS-1:0]  cfg_data,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic                           keep;
    logic [gkb_pkg::GRID_BITS-1:0]  row;
    logic [gkb_pkg::GRID_BITS-1:0]  col;
    logic [gkb_pkg::COUNT_BITS-1:0] count;
  } bucket_result_t;

  logic [gkb_pkg::SIZE_BITS-1:0]  cell_h;
  logic [gkb_pkg::SIZE_BITS-1:0]  cell_w;
  logic [gkb_pkg::GCFG_BITS-1:0]  grid_cfg;
  logic [gkb_pkg::MAXC_BITS-1:0]  cap;
  logic [gkb_pkg::COUNT_BITS-1:0] fill [gkb_pkg::SLOTS];
  bucket_result_t                 due_q [$];
  int                             errs;

  // a zero size maps straight to the last cell, as does any index past it
  function automatic int cell_of(input int coord, input int size, input int last);
    int idx;
    idx = (size == 0) ? last : coord / size;
    return (idx > last) ? last : idx;
  endfunction

  always @(posedge clk) begin : track
    bucket_result_t got;
    bucket_result_t want;
    int             sides;
    int             r;
    int             c;
    int             slot;
    if (!rst_n) begin
      cell_h   = gkb_pkg::RST_CELL_HEIGHT;
      cell_w   = gkb_pkg::RST_CELL_WIDTH;
      grid_cfg = gkb_pkg::RST_GRID_CELLS;
      cap      = gkb_pkg::RST_MAX_PER_CELL;
      foreach (fill[i]) fill[i] = '0;
      due_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gkb_pkg::CFG_CELL_HEIGHT:  cell_h   = cfg_data[gkb_pkg::SIZE_BITS-1:0];
          gkb_pkg::CFG_CELL_WIDTH:   cell_w   = cfg_data[gkb_pkg::SIZE_BITS-1:0];
          gkb_pkg::CFG_GRID_CELLS:   grid_cfg = cfg_data[gkb_pkg::GCFG_BITS-1:0];
          gkb_pkg::CFG_MAX_PER_CELL: cap      = cfg_data[gkb_pkg::MAXC_BITS-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.keep, out_ch.cell_row, out_ch.cell_col, out_ch.cell_count};
        if (due_q.size() == 0) begin
          errs++;
          $error("result transaction with no point outstanding");
        end else begin
          want = due_q.pop_front();
          if (got.keep !== want.keep) begin
            errs++;
            $error("keep: expected %0d, got %0d", want.keep, got.keep);
          end
          if (got.row !== want.row) begin
            errs++;
            $error("cell_row: expected %0d, got %0d", want.row, got.row);
          end
          if (got.col !== want.col) begin
            errs++;
            $error("cell_col: expected %0d, got %0d", want.col, got.col);
          end
          if (got.count !== want.count) begin
            errs++;
            $error("cell_count: expected %0d, got %0d", want.count, got.count);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.new_frame) foreach (fill[i]) fill[i] = '0;
        sides = (grid_cfg == '0) ? 1 :
                (int'(grid_cfg) > gkb_pkg::GRID_MAX) ? gkb_pkg::GRID_MAX : int'(grid_cfg);
        r     = cell_of(int'(in_ch.point_y), int'(cell_h), sides - 1);
        c     = cell_of(int'(in_ch.point_x), int'(cell_w), sides - 1);
        slot  = r * gkb_pkg::GRID_MAX + c;
        want.keep  = 1'b0;
        want.row   = gkb_pkg::GRID_BITS'(r);
        want.col   = gkb_pkg::GRID_BITS'(c);
        want.count = fill[slot];
        // a saturated counter drops the point whatever the cap says
        if (fill[slot] < cap && fill[slot] != '1) begin
          fill[slot] = fill[slot] + 1'b1;
          want.keep  = 1'b1;
          want.count = fill[slot];
        end
        due_q = {due_q, want};
      end
    end
    errors  <= errs;
    pending <= due_q.size();
  end

endmodule

// File: test/tb_grid_keypoint_bucketing.sv
`timescale 1ns / 1ps

module tb_grid_keypoint_bucketing;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [gkb_pkg::CIDX_BITS-1:0] cfg_index;
  logic [gkb_pkg::CFG_BITS-1:0]  cfg_data;
  int                            idle_pct;
  int                            stall_pct;
  int                            errors;
  int                            pending;

  gkb_in_if  in_ch ();
  gkb_out_if out_ch ();

  grid_keypoint_bucketing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gkb_bucket_checker bucket_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_point(input logic [gkb_pkg::COORD_BITS-1:0] x,
                            input logic [gkb_pkg::COORD_BITS-1:0] y,
                            input logic nf);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.point_x   <= x;
    in_ch.point_y   <= y;
    in_ch.new_frame <= nf;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off the sender until every outstanding point has its result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // leaves cfg_we high so back-to-back writes never toggle it within one step
  task automatic reg_write(input logic [gkb_pkg::CIDX_BITS-1:0] idx,
                           input logic [gkb_pkg::CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // unused upper data bits are randomized, the block must ignore them
  task automatic set_config(input int h, input int w, input int g, input int m);
    reg_write(gkb_pkg::CFG_CELL_HEIGHT, gkb_pkg::CFG_BITS'(h));
    reg_write(gkb_pkg::CFG_CELL_WIDTH, gkb_pkg::CFG_BITS'(w));
    reg_write(gkb_pkg::CFG_GRID_CELLS, {7'($urandom), 5'(g)});
    reg_write(gkb_pkg::CFG_MAX_PER_CELL, {4'($urandom), 8'(m)});
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return 4095;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  initial begin
    int g;
    int m;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.new_frame = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = gkb_pkg::CFG_CELL_HEIGHT;
    cfg_data        = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: corners and cell boundaries
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd0, 12'd4095, 1'b0);
    send_point(12'd39, 12'd29, 1'b0);
    send_point(12'd40, 12'd30, 1'b0);

    // zero cell size lands in the last cell
    drain();
    set_config(0, 0, 16, 10);
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd1234, 12'd567, 1'b0);

    // grid of zero acts as one cell; cap of three fills up
    drain();
    set_config(1, 1, 0, 3);
    send_point(12'd5, 12'd9, 1'b1);
    repeat (3) send_point(12'd5, 12'd9, 1'b0);

    // oversize grid clamps to the full grid
    drain();
    set_config(1, 1, 20, 255);
    send_point(12'd4095, 12'd2, 1'b0);
    send_point(12'd15, 12'd16, 1'b0);
    drain();
    set_config(4095, 4095, 31, 255);
    send_point(12'd4095, 12'd4095, 1'b0);

    // cap of zero drops everything
    drain();
    set_config(100, 100, 8, 0);
    send_point(12'd250, 12'd50, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b1);

    // grid shrinks mid-frame, counts keep their slots
    drain();
    set_config(256, 256, 16, 10);
    send_point(12'd300, 12'd300, 1'b1);
    drain();
    set_config(256, 256, 4, 10);
    send_point(12'd300, 12'd300, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(19))
        0:       g = 0;
        1:       g = $urandom_range(17, 31);
        2:       g = 16;
        3:       g = 1;
        default: g = $urandom_range(2, 16);
      endcase
      case ($urandom_range(9))
        0:       m = 0;
        1:       m = 255;
        default: m = $urandom_range(1, 6);
      endcase
      set_config(pick_size(), pick_size(), g, m);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < 90; n++) begin
        send_point(gkb_pkg::COORD_BITS'($urandom), gkb_pkg::COORD_BITS'($urandom),
                   $urandom_range(99) < 3);
      end
    end

    // single cell with the largest cap runs its counter into saturation
    drain();
    set_config(pick_size(), pick_size(), 1, 255);
    idle_pct  = 9;
    stall_pct = 9;
    send_point(gkb_pkg::COORD_BITS'($urandom), gkb_pkg::COORD_BITS'($urandom), 1'b1);
    repeat (300) begin
      send_point(gkb_pkg::COORD_BITS'($urandom), gkb_pkg::COORD_BITS'($urandom), 1'b0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** grid_keypoint_bucketing: PASSED **");
    end else begin
      $display("** grid_keypoint_bucketing: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** grid_keypoint_bucketing: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/gkb_pkg.sv
rtl/gkb_if.sv
rtl/gkb_front.sv
rtl/gkb_queue.sv
rtl/gkb_back.sv
rtl/grid_keypoint_bucketing.sv
test/gkb_bucket_checker.sv
test/tb_grid_keypoint_bucketing.sv
